[src/rfb_pkg.sv]
// Shared types, register indexes and the alpha scaling function of the rectangle blender.
`timescale 1ns / 1ps
package rfb_pkg;

  // One input word: pixel position and the current destination color.
  typedef struct packed {
    logic [11:0] pixel_column;
    logic [11:0] pixel_row;
    logic [7:0]  dest_red;
    logic [7:0]  dest_green;
    logic [7:0]  dest_blue;
    logic [7:0]  dest_alpha;
  } rfb_in_t;

  // One result word: blended pixel and its coverage flag.
  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       covered;
  } rfb_out_t;

  localparam int unsigned CfgIndexW = 3;

  typedef enum logic [CfgIndexW-1:0] {
    REG_DRAW_MODE        = 3'd0,
    REG_LEFT_EDGE        = 3'd1,
    REG_TOP_EDGE         = 3'd2,
    REG_RECT_WIDTH       = 3'd3,
    REG_RECT_HEIGHT      = 3'd4,
    REG_BORDER_THICKNESS = 3'd5,
    REG_FILL_COLOR       = 3'd6
  } rfb_cfg_reg_t;

  localparam logic       MODE_FILL    = 1'b0;
  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
  localparam logic [15:0] ROUND_BIAS  = 16'd128;

  // scale(v, a) = (p + (p >> 8)) >> 8 with p = v * a + 128; never exceeds 255.
  function automatic logic [7:0] scale8(input logic [7:0] v, input logic [7:0] a);
    logic [15:0] p;
    logic [16:0] q;
    p = ({8'd0, v} * {8'd0, a}) + ROUND_BIAS;
    q = {1'b0, p} + {9'd0, p[15:8]};
    return q[15:8];
  endfunction

endpackage

[src/rect_fill_border_alpha_blend_unit.sv]
// Top level of the rectangle fill / border ring source-over blender.
// Datapath: a taken word loads the input register, then the result register, which
//   raises out_valid; the receiver cannot hold the result off and takes it as it comes.
// Throughput: one word per cycle; a new word enters while the last is in the result register.
// busy stays low: the receiver cannot stall, so nothing ever holds the input off.
// Reset (rst_n low, synchronous): all config registers go to 0, pipeline empties.
`timescale 1ns / 1ps
module rect_fill_border_alpha_blend_unit #(
  parameter int unsigned SURFACE_MAX_SIDE = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // pixel input
  input  logic                          start,
  output logic                          busy,
  input  rfb_pkg::rfb_in_t              in_word,
  // blended result
  output logic                          out_valid,
  output rfb_pkg::rfb_out_t             out_word,
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rfb_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);

  // Surface bound, widened to hold the largest allowed side.
  localparam logic [16:0] SideLimit = 17'(SURFACE_MAX_SIDE);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic        draw_mode_r;
  logic [15:0] left_edge_r;
  logic [15:0] top_edge_r;
  logic [14:0] rect_width_r;
  logic [14:0] rect_height_r;
  logic [14:0] border_thickness_r;
  logic [31:0] fill_color_r;

  logic cfg_we;

  // Writes are always taken; the block has no reason to refuse one.
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      draw_mode_r        <= rfb_pkg::MODE_FILL;
      left_edge_r        <= '0;
      top_edge_r         <= '0;
      rect_width_r       <= '0;
      rect_height_r      <= '0;
      border_thickness_r <= '0;
      fill_color_r       <= '0;
    end else if (cfg_we) begin
      case (rfb_pkg::rfb_cfg_reg_t'(cfg_index))
        rfb_pkg::REG_DRAW_MODE:        draw_mode_r        <= cfg_data[0];
        rfb_pkg::REG_LEFT_EDGE:        left_edge_r        <= cfg_data[15:0];
        rfb_pkg::REG_TOP_EDGE:         top_edge_r         <= cfg_data[15:0];
        rfb_pkg::REG_RECT_WIDTH:       rect_width_r       <= cfg_data[14:0];
        rfb_pkg::REG_RECT_HEIGHT:      rect_height_r      <= cfg_data[14:0];
        rfb_pkg::REG_BORDER_THICKNESS: border_thickness_r <= cfg_data[14:0];
        rfb_pkg::REG_FILL_COLOR:       fill_color_r       <= cfg_data;
        default: ;  // unused index: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Derived geometry and source color
  // The user must change config only while idle; no check enforces it. These
  // settle before any word taken after the write reaches the blend stage.
  // All edge coordinates are 18-bit signed: left + width - thickness spans
  // -65535 .. 65534.
  // ---------------------------------------------------------------------------
  logic signed [17:0] left_ext, top_ext, width_ext, height_ext, thick_ext;

  logic signed [17:0] right_r,       right_nxt;
  logic signed [17:0] bottom_r,      bottom_nxt;
  logic signed [17:0] in_left_r,     in_left_nxt;
  logic signed [17:0] in_top_r,      in_top_nxt;
  logic signed [17:0] in_right_r,    in_right_nxt;
  logic signed [17:0] in_bottom_r,   in_bottom_nxt;
  logic               empty_r,       empty_nxt;
  logic               solid_ring_r,  solid_ring_nxt;
  logic               no_ring_r,     no_ring_nxt;
  logic [7:0]         src_red_r,     src_red_nxt;
  logic [7:0]         src_green_r,   src_green_nxt;
  logic [7:0]         src_blue_r,    src_blue_nxt;
  logic [7:0]         keep_r,        keep_nxt;

  always_comb begin
    left_ext   = {{2{left_edge_r[15]}}, left_edge_r};
    top_ext    = {{2{top_edge_r[15]}}, top_edge_r};
    width_ext  = $signed({3'd0, rect_width_r});
    height_ext = $signed({3'd0, rect_height_r});
    thick_ext  = $signed({3'd0, border_thickness_r});

    right_nxt     = left_ext + width_ext;
    bottom_nxt    = top_ext + height_ext;
    in_left_nxt   = left_ext + thick_ext;
    in_top_nxt    = top_ext + thick_ext;
    in_right_nxt  = left_ext + width_ext - thick_ext;
    in_bottom_nxt = top_ext + height_ext - thick_ext;

    empty_nxt      = (rect_width_r == '0) || (rect_height_r == '0);
    no_ring_nxt    = (border_thickness_r == '0);
    // twice the thickness reaching either side fills the whole rectangle
    solid_ring_nxt = ({border_thickness_r, 1'b0} >= {1'b0, rect_width_r}) ||
                     ({border_thickness_r, 1'b0} >= {1'b0, rect_height_r});

    // premultiply the fill color by its own alpha
    src_red_nxt   = rfb_pkg::scale8(fill_color_r[31:24], fill_color_r[7:0]);
    src_green_nxt = rfb_pkg::scale8(fill_color_r[23:16], fill_color_r[7:0]);
    src_blue_nxt  = rfb_pkg::scale8(fill_color_r[15:8],  fill_color_r[7:0]);
    keep_nxt      = rfb_pkg::ALPHA_OPAQUE - fill_color_r[7:0];
  end

  always_ff @(posedge clk) begin
    right_r      <= right_nxt;
    bottom_r     <= bottom_nxt;
    in_left_r    <= in_left_nxt;
    in_top_r     <= in_top_nxt;
    in_right_r   <= in_right_nxt;
    in_bottom_r  <= in_bottom_nxt;
    empty_r      <= empty_nxt;
    solid_ring_r <= solid_ring_nxt;
    no_ring_r    <= no_ring_nxt;
    src_red_r    <= src_red_nxt;
    src_green_r  <= src_green_nxt;
    src_blue_r   <= src_blue_nxt;
    keep_r       <= keep_nxt;
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic             in_take;
  logic             in_valid_r;
  rfb_pkg::rfb_in_t in_r;

  assign busy    = 1'b0;
  assign in_take = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r <= in_word;
    end
  end

  // ---------------------------------------------------------------------------
  // Coverage test and blend
  // ---------------------------------------------------------------------------
  logic signed [17:0] px, py;
  logic               on_surface;
  logic               in_rect;
  logic               on_ring;
  logic               cov;
  logic [7:0]         alpha;
  logic               opaque;
  rfb_pkg::rfb_out_t  res_nxt;
  rfb_pkg::rfb_out_t  res_r;
  logic               out_valid_r;

  always_comb begin
    px     = $signed({6'd0, in_r.pixel_column});
    py     = $signed({6'd0, in_r.pixel_row});
    alpha  = fill_color_r[7:0];
    opaque = (alpha == rfb_pkg::ALPHA_OPAQUE);

    on_surface = ({5'd0, in_r.pixel_column} < SideLimit) &&
                 ({5'd0, in_r.pixel_row} < SideLimit);
    in_rect    = (px >= left_ext) && (px < right_r) &&
                 (py >= top_ext) && (py < bottom_r);
    on_ring    = solid_ring_r ||
                 (px < in_left_r) || (px >= in_right_r) ||
                 (py < in_top_r) || (py >= in_bottom_r);

    cov = (alpha != '0) && on_surface && !empty_r && in_rect &&
          ((draw_mode_r == rfb_pkg::MODE_FILL) || (!no_ring_r && on_ring));

    res_nxt.covered = cov;
    if (!cov) begin
      // pass the destination through untouched
      res_nxt.out_red   = in_r.dest_red;
      res_nxt.out_green = in_r.dest_green;
      res_nxt.out_blue  = in_r.dest_blue;
      res_nxt.out_alpha = in_r.dest_alpha;
    end else if (opaque) begin
      res_nxt.out_red   = src_red_r;
      res_nxt.out_green = src_green_r;
      res_nxt.out_blue  = src_blue_r;
      res_nxt.out_alpha = rfb_pkg::ALPHA_OPAQUE;
    end else begin
      // source over: src + dest * (255 - alpha) / 255, wrapping to 8 bits
      res_nxt.out_red   = src_red_r   + rfb_pkg::scale8(in_r.dest_red,   keep_r);
      res_nxt.out_green = src_green_r + rfb_pkg::scale8(in_r.dest_green, keep_r);
      res_nxt.out_blue  = src_blue_r  + rfb_pkg::scale8(in_r.dest_blue,  keep_r);
      res_nxt.out_alpha = alpha       + rfb_pkg::scale8(in_r.dest_alpha, keep_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: one strobe per word, the receiver takes it as it comes.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = res_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // every result traces back to a word taken into the input register
  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result strobe without an accepted input word");

  // a zero fill alpha never marks a pixel covered
  a_zero_alpha_uncovered: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.covered) |-> ($past(fill_color_r[7:0]) != 8'd0))
    else $error("pixel covered with zero fill alpha");

  // an uncovered pixel passes the destination red and alpha through
  a_uncovered_passthrough: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_word.covered) |->
      (out_word.out_red == $past(in_r.dest_red)) &&
      (out_word.out_alpha == $past(in_r.dest_alpha)))
    else $error("uncovered pixel altered");

  // an opaque fill writes full alpha
  a_opaque_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.covered && $past(opaque)) |->
      (out_word.out_alpha == rfb_pkg::ALPHA_OPAQUE))
    else $error("opaque fill did not produce full alpha");

endmodule

[bench/rect_fill_border_alpha_blend_unit_test.sv]
// Self-checking testbench for the rectangle fill / border ring source-over blender.
`timescale 1ns / 1ps
module rect_fill_border_alpha_blend_unit_test;

  localparam int SURFACE_SIDE = 4096;
  // Idle cycles waited after the last result before touching registers.
  localparam int PIPE_DRAIN   = 4;
  localparam int RANDOM_ITEMS = 1950;
  localparam int CYCLE_LIMIT  = 400000;

  // One complete register setting, each field at its register width.
  typedef struct packed {
    logic        mode;
    logic [15:0] left;
    logic [15:0] top;
    logic [14:0] wid;
    logic [14:0] hgt;
    logic [14:0] thick;
    logic [31:0] color;
  } setting_t;

  // One directed row: setting to run under, pixel word, and an optional typed result.
  typedef struct packed {
    setting_t          setting;
    rfb_pkg::rfb_in_t  pix;
    logic              typed;
    rfb_pkg::rfb_out_t want;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  rfb_pkg::rfb_in_t  in_word = '0;
  logic              out_valid;
  rfb_pkg::rfb_out_t out_word;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [rfb_pkg::CfgIndexW-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  rfb_pkg::rfb_out_t expected_pixels[$];
  dir_row_t directed_rows[$];
  setting_t cur_setting = '0;
  rfb_pkg::rfb_out_t head;
  int err_count = 0;
  int pixels_checked = 0;
  int pixels_covered = 0;
  int settings_used = 0;
  int cycle_count = 0;

  rect_fill_border_alpha_blend_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Bound the run: a hung handshake or a lost result ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_pixels.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Rounded v * a / 255 with the block's bias-and-fold trick.
  function automatic int unsigned premul(int unsigned v, int unsigned a);
    int unsigned prod;
    prod = v * a + 128;
    return (prod + (prod >> 8)) >> 8;
  endfunction

  // Predict one blended pixel under setting c.
  function automatic rfb_pkg::rfb_out_t blend_pixel(rfb_pkg::rfb_in_t p, setting_t c);
    longint x, y, l, t, w, h, k;
    int unsigned a, keep;
    bit hit;
    rfb_pkg::rfb_out_t r;
    x = p.pixel_column;
    y = p.pixel_row;
    l = longint'($signed(c.left));
    t = longint'($signed(c.top));
    w = c.wid;
    h = c.hgt;
    k = c.thick;
    a = c.color[7:0];
    hit = (a != 0) && (x < SURFACE_SIDE) && (y < SURFACE_SIDE) && (w != 0) && (h != 0) &&
          (x >= l) && (x < l + w) && (y >= t) && (y < t + h);
    // Border mode: zero thickness draws nothing; a ring that meets itself fills.
    if (hit && c.mode != rfb_pkg::MODE_FILL) begin
      if (k == 0)
        hit = 1'b0;
      else if (!(2 * k >= w || 2 * k >= h))
        hit = (x < l + k) || (x >= l + w - k) || (y < t + k) || (y >= t + h - k);
    end
    if (!hit) begin
      r = {p.dest_red, p.dest_green, p.dest_blue, p.dest_alpha, 1'b0};
    end else if (a == 255) begin
      r.out_red   = 8'(premul(c.color[31:24], a));
      r.out_green = 8'(premul(c.color[23:16], a));
      r.out_blue  = 8'(premul(c.color[15:8], a));
      r.out_alpha = 8'd255;
      r.covered   = 1'b1;
    end else begin
      // Source-over: premultiplied source plus the scaled destination, wrapping.
      keep = 255 - a;
      r.out_red   = 8'(premul(c.color[31:24], a) + premul(p.dest_red, keep));
      r.out_green = 8'(premul(c.color[23:16], a) + premul(p.dest_green, keep));
      r.out_blue  = 8'(premul(c.color[15:8], a) + premul(p.dest_blue, keep));
      r.out_alpha = 8'(a + premul(p.dest_alpha, keep));
      r.covered   = 1'b1;
    end
    return r;
  endfunction

  function automatic setting_t mk_setting(logic mode, logic [15:0] left, logic [15:0] top,
                                          logic [14:0] wid, logic [14:0] hgt,
                                          logic [14:0] thick, logic [31:0] color);
    return {mode, left, top, wid, hgt, thick, color};
  endfunction

  function automatic rfb_pkg::rfb_in_t pix(logic [11:0] col, logic [11:0] row,
                                           logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                           logic [7:0] a);
    return {col, row, r, g, b, a};
  endfunction

  function automatic rfb_pkg::rfb_out_t res(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                            logic [7:0] a, logic cov);
    return {r, g, b, a, cov};
  endfunction

  // An uncovered pixel comes back as it went in.
  function automatic rfb_pkg::rfb_out_t unchanged(rfb_pkg::rfb_in_t p);
    return {p.dest_red, p.dest_green, p.dest_blue, p.dest_alpha, 1'b0};
  endfunction

  task automatic add_row(setting_t c, rfb_pkg::rfb_in_t p, logic typed,
                         rfb_pkg::rfb_out_t want);
    directed_rows.push_back({c, p, typed, want});
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offset from a rectangle origin, aimed at the edges and the inner ring boundary.
  function automatic int near_edge(int base, int span, int ring);
    int off;
    case ($urandom_range(0, 4))
      0: off = int'($urandom_range(0, 6)) - 3;
      1: off = span + int'($urandom_range(0, 6)) - 3;
      2: off = ring + int'($urandom_range(0, 4)) - 2;
      3: off = span - ring + int'($urandom_range(0, 4)) - 2;
      default: off = int'($urandom_range(0, span));
    endcase
    return base + off;
  endfunction

  function automatic setting_t random_setting();
    setting_t c;
    logic [7:0] alpha;
    c.mode = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 9) == 0) begin
      // Full-range rectangle: reaches the signed and width extremes.
      c.left  = 16'($urandom);
      c.top   = 16'($urandom);
      c.wid   = 15'($urandom);
      c.hgt   = 15'($urandom);
      c.thick = 15'($urandom);
    end else begin
      // Small rectangle on or just off the surface.
      c.left = 16'($urandom_range(0, 4200) - 100);
      c.top  = 16'($urandom_range(0, 4200) - 100);
      c.wid  = 15'($urandom_range(0, 40));
      c.hgt  = 15'($urandom_range(0, 40));
      case ($urandom_range(0, 3))
        0: c.thick = 15'($urandom_range(0, 3));
        1: c.thick = 15'((c.wid >> 1) + $urandom_range(0, 1));
        2: c.thick = 15'((c.hgt >> 1) + $urandom_range(0, 1));
        default: c.thick = 15'($urandom_range(0, 12));
      endcase
    end
    case ($urandom_range(0, 5))
      0: alpha = 8'd0;
      1: alpha = 8'd255;
      2: alpha = $urandom_range(0, 1) ? 8'd1 : 8'd254;
      default: alpha = 8'($urandom);
    endcase
    c.color = {24'($urandom), alpha};
    return c;
  endfunction

  function automatic rfb_pkg::rfb_in_t random_pixel(setting_t c);
    rfb_pkg::rfb_in_t p;
    int col, row;
    p = 56'({$urandom, $urandom});
    // Most pixels land around the rectangle; the rest anywhere on the surface.
    if ($urandom_range(0, 4) != 0) begin
      col = near_edge(int'($signed(c.left)), int'(c.wid), int'(c.thick));
      row = near_edge(int'($signed(c.top)), int'(c.hgt), int'(c.thick));
      if (col >= 0 && col < SURFACE_SIDE) p.pixel_column = 12'(col);
      if (row >= 0 && row < SURFACE_SIDE) p.pixel_row = 12'(row);
    end
    return p;
  endfunction

  // Present one register word and hold it until the channel takes it.
  task automatic write_reg(rfb_pkg::rfb_cfg_reg_t idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Drain the pipeline, then load every register; junk above each narrower field must be dropped.
  task automatic program_regs(setting_t c);
    start <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
    write_reg(rfb_pkg::REG_DRAW_MODE,        {31'($urandom), c.mode});
    write_reg(rfb_pkg::REG_LEFT_EDGE,        {16'($urandom), c.left});
    write_reg(rfb_pkg::REG_TOP_EDGE,         {16'($urandom), c.top});
    write_reg(rfb_pkg::REG_RECT_WIDTH,       {17'($urandom), c.wid});
    write_reg(rfb_pkg::REG_RECT_HEIGHT,      {17'($urandom), c.hgt});
    write_reg(rfb_pkg::REG_BORDER_THICKNESS, {17'($urandom), c.thick});
    write_reg(rfb_pkg::REG_FILL_COLOR,       c.color);
    cfg_valid <= 1'b0;
    cur_setting = c;
    settings_used++;
  endtask

  // Idle for the given gap, then offer the pixel word and queue its result on acceptance.
  // Leave start high on return: the next call either lowers it or reuses it.
  task automatic send_pixel(rfb_pkg::rfb_in_t p, rfb_pkg::rfb_out_t want, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_word <= p;
    do @(posedge clk); while (busy);
    expected_pixels.push_back(want);
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      err_count++;
    end
  endtask

  // Results cannot be held off: take each strobe at the edge that ends it.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_word);
        err_count++;
      end else begin
        head = expected_pixels.pop_front();
        check_field("out_red",   head.out_red,   out_word.out_red);
        check_field("out_green", head.out_green, out_word.out_green);
        check_field("out_blue",  head.out_blue,  out_word.out_blue);
        check_field("out_alpha", head.out_alpha, out_word.out_alpha);
        check_field("covered",   head.covered,   out_word.covered);
        pixels_checked++;
        if (head.covered) pixels_covered++;
      end
    end
  end

  initial begin
    setting_t s_zero_alpha, s_fill, s_no_w, s_no_h, s_no_ring, s_ring, s_thick;
    setting_t s_offside, s_far, s_neg, s_huge, s_faint, s_rand;
    rfb_pkg::rfb_in_t p;
    int sent;
    int n;
    bit burst;

    s_zero_alpha = mk_setting(rfb_pkg::MODE_FILL, 0, 0, 16, 16, 0, 32'hA0B0C000);
    s_fill    = mk_setting(rfb_pkg::MODE_FILL, 10, 20, 5, 3, 0, 32'h80FF20FF);
    s_no_w    = mk_setting(rfb_pkg::MODE_FILL, 10, 20, 0, 3, 0, 32'h80FF20FF);
    s_no_h    = mk_setting(rfb_pkg::MODE_FILL, 10, 20, 5, 0, 0, 32'h80FF20FF);
    s_no_ring = mk_setting(~rfb_pkg::MODE_FILL, 100, 100, 20, 10, 0, 32'hFFFFFFFF);
    s_ring    = mk_setting(~rfb_pkg::MODE_FILL, 100, 100, 20, 10, 2, 32'h40608080);
    s_thick   = mk_setting(~rfb_pkg::MODE_FILL, 100, 100, 20, 10, 5, 32'h123456FF);
    s_offside = mk_setting(rfb_pkg::MODE_FILL, -5, -5, 10, 10, 0, 32'hC0302090);
    s_far     = mk_setting(~rfb_pkg::MODE_FILL, 16'h7FFF, 16'h7FFF, 15'h7FFF, 15'h7FFF,
                           15'h7FFF, 32'hFFFFFFFF);
    s_neg     = mk_setting(rfb_pkg::MODE_FILL, 16'h8000, 16'h8000, 15'h7FFF, 15'h7FFF, 0,
                           32'hFFFFFFFF);
    s_huge    = mk_setting(rfb_pkg::MODE_FILL, 0, 0, 15'h7FFF, 15'h7FFF, 0, 32'h01020380);
    s_faint   = mk_setting(rfb_pkg::MODE_FILL, 0, 0, 15'h7FFF, 15'h7FFF, 0, 32'hFFFFFF01);

    // Reset values: nothing drawn, pixels pass through.
    add_row('0, pix(0, 0, 8'h00, 8'h00, 8'h00, 8'h00), 1, res(0, 0, 0, 0, 0));
    add_row('0, pix(4095, 4095, 8'hFF, 8'hFF, 8'hFF, 8'hFF),
            1, res(8'hFF, 8'hFF, 8'hFF, 8'hFF, 0));
    // Zero alpha covers nothing.
    p = pix(3, 3, 8'h12, 8'h34, 8'h56, 8'h78);
    add_row(s_zero_alpha, p, 1, unchanged(p));
    // Opaque fill: color replaces the pixel; one step past the left, right and bottom edges is untouched.
    add_row(s_fill, pix(10, 20, 8'h5A, 8'hA5, 8'h0F, 8'hF0), 1, res(8'h80, 8'hFF, 8'h20, 8'hFF, 1));
    add_row(s_fill, pix(14, 22, 8'h00, 8'h00, 8'h00, 8'h00), 1, res(8'h80, 8'hFF, 8'h20, 8'hFF, 1));
    p = pix(15, 22, 8'h11, 8'h22, 8'h33, 8'h44);
    add_row(s_fill, p, 1, unchanged(p));
    p = pix(9, 20, 8'h55, 8'h66, 8'h77, 8'h88);
    add_row(s_fill, p, 1, unchanged(p));
    p = pix(10, 23, 8'h99, 8'hAA, 8'hBB, 8'hCC);
    add_row(s_fill, p, 1, unchanged(p));
    // Empty rectangle in either dimension.
    p = pix(10, 20, 8'h01, 8'h02, 8'h03, 8'h04);
    add_row(s_no_w, p, 1, unchanged(p));
    add_row(s_no_h, p, 1, unchanged(p));
    // Border of zero thickness.
    p = pix(100, 100, 8'h10, 8'h20, 8'h30, 8'h40);
    add_row(s_no_ring, p, 1, unchanged(p));
    // Two-pixel ring, half alpha: each side of the ring, and the hollow inside.
    add_row(s_ring, pix(100, 100, 8'hFF, 8'h00, 8'h80, 8'h7F), 0, '0);
    add_row(s_ring, pix(101, 103, 8'h20, 8'h40, 8'h60, 8'h80), 0, '0);
    add_row(s_ring, pix(118, 104, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 0, '0);
    add_row(s_ring, pix(110, 108, 8'h01, 8'hFE, 8'h33, 8'hCC), 0, '0);
    p = pix(117, 107, 8'hDE, 8'hAD, 8'hBE, 8'hEF);
    add_row(s_ring, p, 1, unchanged(p));
    p = pix(105, 105, 8'h0A, 8'h0B, 8'h0C, 8'h0D);
    add_row(s_ring, p, 1, unchanged(p));
    // Ring thick enough to meet itself fills the center.
    add_row(s_thick, pix(110, 105, 8'h77, 8'h77, 8'h77, 8'h77),
            1, res(8'h12, 8'h34, 8'h56, 8'hFF, 1));
    // Rectangle hanging off the top-left corner of the surface.
    add_row(s_offside, pix(0, 0, 8'h80, 8'h80, 8'h80, 8'h80), 0, '0);
    add_row(s_offside, pix(4, 4, 8'hFF, 8'h00, 8'hFF, 8'h00), 0, '0);
    p = pix(5, 5, 8'h21, 8'h43, 8'h65, 8'h87);
    add_row(s_offside, p, 1, unchanged(p));
    // Register extremes: rectangles that miss the surface entirely.
    p = pix(4095, 4095, 8'h01, 8'h02, 8'h04, 8'h08);
    add_row(s_far, p, 1, unchanged(p));
    p = pix(0, 0, 8'h10, 8'h20, 8'h40, 8'h80);
    add_row(s_neg, p, 1, unchanged(p));
    // Whole-surface fills at partial alpha.
    add_row(s_huge, pix(4095, 4095, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 0, '0);
    add_row(s_faint, pix(2048, 1, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 0, '0);

    // Hold reset, then release it once.
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table; reprogram only when the setting changes.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].setting != cur_setting)
        program_regs(directed_rows[i].setting);
      send_pixel(directed_rows[i].pix,
                 directed_rows[i].typed ? directed_rows[i].want
                                        : blend_pixel(directed_rows[i].pix, cur_setting),
                 pick_gap());
    end

    // Random phases: a fresh setting, then a run of pixels around its rectangle.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      s_rand = random_setting();
      program_regs(s_rand);
      burst = ($urandom_range(0, 3) == 0);
      n = $urandom_range(8, 60);
      repeat (n) begin
        p = random_pixel(cur_setting);
        send_pixel(p, blend_pixel(p, cur_setting), burst ? 0 : pick_gap());
        sent++;
      end
    end

    // Drop start and let the last results come out.
    start <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);

    $display("Checked %0d blended pixels (%0d covered) across %0d register settings,",
             pixels_checked, pixels_covered, settings_used);
    $display("fill and border modes, edge and ring boundaries, and alpha extremes.");
    if (err_count == 0 && expected_pixels.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[files.f]
src/rfb_pkg.sv
src/rect_fill_border_alpha_blend_unit.sv
bench/rect_fill_border_alpha_blend_unit_test.sv
